[sv/stems_pkg.sv]
// Shared constants and control types for the sorted-table exact-match search.
// Used by the datapath, the controller, the top level and the port checker.
`default_nettype none

package stems_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);

	// Field widths fixed by the interface
	localparam int INDEX_W = 10;
	localparam int CNT_W   = 11;
	localparam int KEY_W   = 64;
	localparam int VAL_W   = 64;

	// Table depth as a count-register value, for clamping and range checks
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // write one entry from the accepted request
		logic start;   // capture a lookup request and reset the bounds
		logic step;    // narrow the bounds and issue the next table read
		logic finish;  // test the final entry and load the result register
	} stems_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last;      // bounds have met, the read just issued is the final one
		logic out_free;  // result register can take a new result this cycle
	} stems_sts_t;

endpackage

`default_nettype wire

[sv/sorted_table_exact_match_search_top.sv]
// Top level of the sorted-table exact-match search.
// Depends on stems_pkg, stems_ctrl and stems_dp.
//
// Holds up to 1024 key/value pairs sorted ascending by unsigned 64-bit key.
// A request with mode 0 writes one entry without making the block busy; a
// request with mode 1 binary-searches the first entry_count entries for the
// lower bound of key and returns found plus the value (zero on a miss). An
// empty table always misses. A lookup holds in_stall while it searches and
// while it waits to load its result, and the next request is taken once the
// block is idle again. The search loop makes one probe per cycle through the
// single registered read port of the key memory. The result waits in an
// output register, so a finished lookup only stalls if an earlier
// result has not been taken. Write entry_count only while no lookup is in
// flight; cfg_ready is always high. The table has no reset: search only
// over entries that were written.
`default_nettype none

module sorted_table_exact_match_search_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [stems_pkg::CNT_W-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          mode,
	input  wire logic [stems_pkg::INDEX_W-1:0] entry_index,
	input  wire logic [stems_pkg::KEY_W-1:0]   key,
	input  wire logic [stems_pkg::VAL_W-1:0]   entry_value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               found,
	output logic [stems_pkg::VAL_W-1:0]        match_value
);
	import stems_pkg::*;

	stems_cmd_t cmd;
	stems_sts_t sts;

	// Register writes land at once
	assign cfg_ready = 1'b1;

	stems_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	stems_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.entry_index (entry_index),
		.key         (key),
		.entry_value (entry_value),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.found       (found),
		.match_value (match_value)
	);

endmodule

`default_nettype wire

[sv/stems_dp.sv]
// Datapath: key/value table memories, search bounds, entry count register
// and the result register. Depends on stems_pkg; driven by stems_ctrl.
`default_nettype none

module stems_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire stems_pkg::stems_cmd_t      cmd,
	output stems_pkg::stems_sts_t           sts,
	input  wire logic                       cfg_valid,
	input  wire logic [stems_pkg::CNT_W-1:0]   cfg_data,
	input  wire logic [stems_pkg::INDEX_W-1:0] entry_index,
	input  wire logic [stems_pkg::KEY_W-1:0]   key,
	input  wire logic [stems_pkg::VAL_W-1:0]   entry_value,
	input  wire logic                       out_stall,
	output logic                            out_valid,
	output logic                            found,
	output logic [stems_pkg::VAL_W-1:0]        match_value
);
	import stems_pkg::*;

	logic [KEY_W-1:0]  key_mem [TABLE_DEPTH];
	logic [VAL_W-1:0]  val_mem [TABLE_DEPTH];

	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  n_used;
	logic [KEY_W-1:0]  key_q;
	logic [KEY_W-1:0]  rd_key_q;
	logic [VAL_W-1:0]  rd_val_q;
	logic [ADDR_W-1:0] lo_q;
	logic [ADDR_W-1:0] hi_q;
	logic [ADDR_W-1:0] prb_q;
	logic              have_q;
	logic              empty_q;
	logic [ADDR_W-1:0] lo_n;
	logic [ADDR_W-1:0] hi_n;
	logic [ADDR_W-1:0] span;
	logic [ADDR_W-1:0] probe;
	logic              hit;
	logic              out_valid_q;
	logic              found_q;
	logic [VAL_W-1:0]  value_q;

	// Hold the entry count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cfg_valid) begin
			cnt_q <= cfg_data;
		end
	end

	// Clamp the count to the table depth
	assign n_used = (cnt_q > DEPTH_CNT) ? DEPTH_CNT : cnt_q;

	// Write one entry on a load request, drop out-of-range positions
	always_ff @(posedge clk) begin
		if (cmd.load && (CNT_W'(entry_index) < DEPTH_CNT)) begin
			key_mem[ADDR_W'(entry_index)] <= key;
			val_mem[ADDR_W'(entry_index)] <= entry_value;
		end
	end

	// Fold in the outcome of the last probe, then pick the next midpoint
	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if (have_q) begin
			if (rd_key_q < key_q) begin
				lo_n = prb_q + ADDR_W'(1);
			end else begin
				hi_n = prb_q;
			end
		end
	end

	assign span  = hi_n - lo_n;
	assign probe = lo_n + (span >> 1);

	// Read the table at the probe; once the bounds meet this is the final entry
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			rd_key_q <= key_mem[probe];
			rd_val_q <= val_mem[probe];
		end
	end

	// Advance the search bounds
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q   <= key;
			lo_q    <= '0;
			hi_q    <= (n_used == '0) ? '0 : ADDR_W'(n_used - CNT_W'(1));
			empty_q <= (n_used == '0);
		end else if (cmd.step) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			prb_q <= probe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.start) begin
			have_q <= 1'b0;
		end else if (cmd.step) begin
			have_q <= 1'b1;
		end
	end

	// Test the final entry for an exact match
	assign hit = !empty_q && (rd_key_q == key_q);

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			found_q <= hit;
			value_q <= hit ? rd_val_q : '0;
		end
	end

	assign sts.last     = (lo_n >= hi_n);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign match_value = value_q;

endmodule

`default_nettype wire

[sv/stems_ctrl.sv]
// Controller: sequences table loads and the lookup search over the datapath.
// Depends on stems_pkg for the command and status types.
`default_nettype none

module stems_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  mode,
	input  wire stems_pkg::stems_sts_t sts,
	output logic                       in_stall,
	output stems_pkg::stems_cmd_t      cmd
);
	import stems_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_FINAL  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_n;
	logic       accept;

	// Take requests only between lookups
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	// Drive datapath commands
	assign cmd.load   = accept && !mode;
	assign cmd.start  = accept && mode;
	assign cmd.step   = (state_q == ST_SEARCH);
	assign cmd.finish = (state_q == ST_FINAL) && sts.out_free;

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && mode) begin
					state_n = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (sts.last) begin
					state_n = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (sts.out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

`default_nettype wire

[sv/stems_chk.sv]
// Port checker for the sorted-table exact-match search, bound to the top level.
// Depends on stems_pkg for field widths.
`default_nettype none

module stems_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          cfg_valid,
	input wire logic                          cfg_ready,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          mode,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic                          found,
	input wire logic [stems_pkg::VAL_W-1:0]   match_value
);
	import stems_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(match_value))
		else $error("stalled result changed");

	// A miss carries a zero value
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_value == '0)
		else $error("miss with nonzero value");

	// Only an accepted lookup starts a busy period
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid) && $past(mode))
		else $error("stall without a lookup request");

	// An accepted lookup blocks the next request
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode |=> in_stall)
		else $error("lookup did not hold off the input");

	// A load never makes the block busy
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !mode && !(cfg_valid && !cfg_ready) |=> !in_stall)
		else $error("load stalled the input");

endmodule

bind sorted_table_exact_match_search_top stems_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.mode        (mode),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.found       (found),
	.match_value (match_value)
);

`default_nettype wire

[sim/sorted_table_exact_match_search_top_tb.sv]
// Self-checking testbench for the sorted-table exact-match search top level.
// Depends on stems_pkg and sorted_table_exact_match_search_top; loads tables,
// sets the entry count and checks each lookup against a local search model.

module sorted_table_exact_match_search_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stems_pkg::*;

	localparam bit MODE_LOAD   = 1'b0;
	localparam bit MODE_LOOKUP = 1'b1;
	localparam int RANDOM_ITEMS = 340;
	localparam int SETTLE_CYCLES = 16;
	localparam int FILL_DEPTH = 256;

	typedef struct packed {
		logic               mode;
		logic [INDEX_W-1:0] idx;
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
	} table_req_t;

	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] value;
	} search_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = MODE_LOAD;
	logic [INDEX_W-1:0] entry_index = '0;
	logic [KEY_W-1:0] key = '0;
	logic [VAL_W-1:0] entry_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic found;
	logic [VAL_W-1:0] match_value;

	// Requests waiting to be sent and lookup results waiting to arrive
	table_req_t req_queue[$];
	search_result_t pending_results[$];

	// Table contents and entry count as the block should hold them
	bit [KEY_W-1:0] tbl_key [TABLE_DEPTH];
	bit [VAL_W-1:0] tbl_val [TABLE_DEPTH];
	int unsigned used_count = 0;

	// Keys the stimulus has queued for each position, used to aim lookups
	bit [KEY_W-1:0] plan_key [TABLE_DEPTH];

	bit quiet = 1'b0;
	int send_gap = 0;
	int hold_gap = 0;
	int fail_count = 0;
	int load_count = 0;
	int lookup_count = 0;
	int hit_count = 0;
	int count_settings = 0;
	int items_queued = 0;

	sorted_table_exact_match_search_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.entry_index(entry_index),
		.key        (key),
		.entry_value(entry_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.match_value(match_value)
	);

	always #1 clk = ~clk;

	// Lower-bound binary search over the entries in use, then an equality test
	function automatic search_result_t search_table(input logic [KEY_W-1:0] k);
		search_result_t res;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		res = '0;
		if (used_count == 0)
			return res;
		lo = 0;
		hi = used_count - 1;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (tbl_key[mid] < k)
				lo = mid + 1;
			else
				hi = mid;
		end
		if (tbl_key[lo] == k) begin
			res.found = 1'b1;
			res.value = tbl_val[lo];
		end
		return res;
	endfunction

	// Request driver: update the table model on acceptance, then send the next
	always @(posedge clk or negedge arst_n) begin : request_driver
		table_req_t req;
		search_result_t res;
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= MODE_LOAD;
			entry_index <= '0;
			key <= '0;
			entry_value <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				if (mode == MODE_LOAD) begin
					tbl_key[entry_index] = key;
					tbl_val[entry_index] = entry_value;
					load_count++;
				end else begin
					res = search_table(key);
					pending_results.push_back(res);
					lookup_count++;
					if (res.found)
						hit_count++;
				end
			end
			// advance only when idle or when the held request was taken
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (req_queue.size() != 0) begin
					req = req_queue.pop_front();
					mode <= req.mode;
					entry_index <= req.idx;
					key <= req.key;
					entry_value <= req.value;
					in_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 11) == 0)
						send_gap = $urandom_range(1, 18);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each taken result with the oldest expectation
	always @(posedge clk or negedge arst_n) begin : result_monitor
		search_result_t exp_res;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, found %0b value %h",
						$time, found, match_value);
					fail_count++;
				end else begin
					exp_res = pending_results.pop_front();
					if (found !== exp_res.found) begin
						$display("%0t: found mismatch, expected %0b actual %0b",
							$time, exp_res.found, found);
						fail_count++;
					end
					if (match_value !== exp_res.value) begin
						$display("%0t: match_value mismatch, expected %h actual %h",
							$time, exp_res.value, match_value);
						fail_count++;
					end
				end
			end
			// stall in bursts, never once the run is in its quiet tail
			if (hold_gap > 0) begin
				hold_gap--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				hold_gap = $urandom_range(1, 18) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic push_load(input int unsigned idx, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		table_req_t req;
		req.mode = MODE_LOAD;
		req.idx = INDEX_W'(idx);
		req.key = k;
		req.value = v;
		plan_key[idx] = k;
		req_queue.push_back(req);
		items_queued++;
	endtask

	task automatic push_lookup(input logic [KEY_W-1:0] k);
		table_req_t req;
		req.mode = MODE_LOOKUP;
		req.idx = INDEX_W'($urandom);
		req.key = k;
		req.value = {$urandom, $urandom};
		req_queue.push_back(req);
		items_queued++;
	endtask

	// Aim most lookups at stored keys or their neighbors
	task automatic push_random_lookup(input int unsigned n);
		int unsigned pick;
		logic [KEY_W-1:0] k;
		pick = $urandom_range(0, 9);
		k = {$urandom, $urandom};
		if (n != 0 && pick >= 2 && pick < 7)
			k = plan_key[$urandom_range(0, n - 1)];
		else if (n != 0 && pick == 7)
			k = plan_key[$urandom_range(0, n - 1)] + 64'd1;
		else if (n != 0 && pick == 8)
			k = plan_key[$urandom_range(0, n - 1)] - 64'd1;
		else if (pick == 9)
			k = $urandom_range(0, 1) ? '1 : '0;
		push_lookup(k);
	endtask

	// Write positions 0..n-1 with ascending keys; narrow steps give duplicates
	task automatic load_sorted(input int unsigned n, input int unsigned step_bits);
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] step_mask;
		step_mask = (64'd1 << step_bits) - 64'd1;
		k = {$urandom, $urandom} >> 1;
		for (int unsigned i = 0; i < n; i++) begin
			push_load(i, k, {$urandom, $urandom});
			k += {$urandom, $urandom} & step_mask;
		end
	endtask

	// Wait for all requests and results to drain, then for trailing loads
	task automatic settle();
		@(posedge clk);
		while (req_queue.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_entry_count(input int unsigned n);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= CNT_W'(n);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		used_count = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
		count_settings++;
	endtask

	function automatic int unsigned pick_count();
		case ($urandom_range(0, 19))
			0: return 0;
			1: return 1;
			2: return 2;
			3: return FILL_DEPTH;
			4: return FILL_DEPTH - 1;
			5: return $urandom_range(65, FILL_DEPTH);
			default: return $urandom_range(3, 64);
		endcase
	endfunction

	initial begin : stimulus
		int unsigned n;
		int unsigned step_choice [4];
		int random_start;
		step_choice = '{0, 2, 8, 53};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table after reset: every lookup misses
		push_lookup('0);
		push_lookup('1);
		push_load(0, '0, '1);
		push_load(1, 64'd5, '0);
		push_load(2, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555);
		push_load(3, '1, 64'hAAAA_AAAA_AAAA_AAAA);
		push_load(TABLE_DEPTH - 1, {$urandom, $urandom}, {$urandom, $urandom});
		push_lookup(64'd5);
		settle();

		// four entries: hits at both ends, a zero value, unsigned ordering
		set_entry_count(4);
		push_lookup('0);
		push_lookup(64'd5);
		push_lookup(64'd4);
		push_lookup(64'h8000_0000_0000_0000);
		push_lookup(64'h7FFF_FFFF_FFFF_FFFF);
		push_lookup('1);
		push_lookup(64'hFFFF_FFFF_FFFF_FFFE);
		settle();
		set_entry_count(1);
		push_lookup('0);
		push_lookup(64'd5);
		settle();

		// break the ordering and search the unsorted table
		set_entry_count(4);
		push_load(1, '1, 64'h0000_0000_0000_1234);
		push_lookup(64'h8000_0000_0000_0000);
		push_lookup('1);
		settle();

		// fill a sorted prefix in order and search it
		load_sorted(FILL_DEPTH, 53);
		settle();
		set_entry_count(FILL_DEPTH);
		repeat (60) push_random_lookup(FILL_DEPTH);
		settle();

		// full count: park a max key at the first midpoint so every probe
		// of a key within the prefix stays on written entries
		push_load(TABLE_DEPTH / 2 - 1, '1, {$urandom, $urandom});
		settle();
		set_entry_count(TABLE_DEPTH);
		repeat (12) push_lookup(plan_key[$urandom_range(0, FILL_DEPTH - 1)]);

		// random phases: new count, mostly fresh sorted prefixes, some noise loads
		random_start = items_queued;
		while (items_queued - random_start < RANDOM_ITEMS) begin
			if (items_queued - random_start >= RANDOM_ITEMS - 80)
				quiet = 1'b1;
			settle();
			n = pick_count();
			set_entry_count(n);
			if (n <= 64 && $urandom_range(0, 3) != 0)
				load_sorted(n, step_choice[$urandom_range(0, 3)]);
			repeat ($urandom_range(4, 20)) begin
				if ($urandom_range(0, 7) == 0)
					push_load($urandom_range(0, TABLE_DEPTH - 1),
						{$urandom, $urandom}, {$urandom, $urandom});
				else
					push_random_lookup(n);
			end
		end
		settle();

		$display("Checked %0d lookups (%0d hits, %0d misses) and %0d table loads,",
			lookup_count, hit_count, lookup_count - hit_count, load_count);
		$display("over %0d entry-count settings from an empty to a full table.",
			count_settings);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Hard stop if the block hangs
	initial begin : watchdog
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
sv/stems_pkg.sv
sv/stems_dp.sv
sv/stems_ctrl.sv
sv/sorted_table_exact_match_search_top.sv
sv/stems_chk.sv
sim/sorted_table_exact_match_search_top_tb.sv
